[rtl/load_adc_register_device_top_defines.svh]
// ---------------------------------------------------------------------------
// Load ADC register device: assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef LOAD_ADC_REGISTER_DEVICE_TOP_DEFINES_SVH
`define LOAD_ADC_REGISTER_DEVICE_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define LADC_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define LADC_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/ladc_pkg.sv]
// ---------------------------------------------------------------------------
// Load ADC register device package
// Request codes, register map, power-control bits and the rate table.
// ---------------------------------------------------------------------------
`default_nettype none

package ladc_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_t;

  // Register map
  localparam logic [4:0] ADDR_POWER    = 5'h00;
  localparam logic [4:0] ADDR_CTRL1    = 5'h01;
  localparam logic [4:0] ADDR_CTRL2    = 5'h02;
  localparam logic [4:0] ADDR_ADC_HI   = 5'h12;
  localparam logic [4:0] ADDR_ADC_MID  = 5'h13;
  localparam logic [4:0] ADDR_ADC_LO   = 5'h14;
  localparam logic [4:0] ADDR_CLOCK    = 5'h15;
  localparam logic [4:0] ADDR_AMP_CAL  = 5'h1C;
  localparam logic [4:0] ADDR_REVISION = 5'h1F;

  localparam logic [7:0] REVISION_ID = 8'h0F;

  // Power control bit positions
  localparam int PWR_DIGITAL_BIT = 1;
  localparam int PWR_ANALOG_BIT  = 2;
  localparam int PWR_READY_BIT   = 3;
  localparam int PWR_CONV_BIT    = 5;

  localparam int INTERVAL_W = 17;

  typedef logic [INTERVAL_W-1:0] interval_t;

  // Conversion interval in microseconds for a rate code.
  function automatic interval_t rate_interval(input logic [2:0] rate);
    interval_t iv;
    unique case (rate)
      3'd0:    iv = INTERVAL_W'(100000);
      3'd1:    iv = INTERVAL_W'(50000);
      3'd2:    iv = INTERVAL_W'(25000);
      3'd3:    iv = INTERVAL_W'(12500);
      3'd4:    iv = INTERVAL_W'(3125);
      default: iv = INTERVAL_W'(100000);
    endcase
    return iv;
  endfunction

  function automatic logic is_powered(input logic [7:0] pc);
    return pc[PWR_DIGITAL_BIT] & pc[PWR_ANALOG_BIT];
  endfunction

endpackage

`default_nettype wire

[rtl/load_adc_register_device_top.sv]
// ---------------------------------------------------------------------------
// Load ADC register device
// Register-mapped 24-bit load ADC: bus reads, bus writes and timed samples.
// ---------------------------------------------------------------------------
// Every input transfer (read, write or tick) yields exactly one result
// transfer. The block takes one item per clock when the output side keeps
// up. The item lands in an input register, is decoded against the register
// file by short logic and lands in the result register, where the register
// file updates in the same edge. A result that waits on out_ready does not
// block intake of one further item in the input
// register. Reads return the register byte as it stood before the access's
// power-ready update; unimplemented addresses read 0 and ignore writes;
// ticks convert only while both power-up bits are set and the rate interval
// (control_two bits 6..4) has elapsed in wrapping microsecond time.
// ---------------------------------------------------------------------------
`default_nettype none

module load_adc_register_device_top
  import ladc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic [4:0]         reg_address,
  input  wire logic [7:0]         write_data,
  input  wire logic [31:0]        time_now,
  input  wire logic signed [23:0] load_counts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              read_data,
  output logic                    sample_taken
);

  // Input register
  logic        in_full;
  logic [1:0]  req_q;
  logic [4:0]  addr_q;
  logic [7:0]  wdata_q;
  logic [31:0] now_q;
  logic [23:0] sample_q;

  // Register file
  logic [7:0]  power_control, power_control_next;
  logic [7:0]  control_one, control_one_next;
  logic [7:0]  control_two, control_two_next;
  logic [23:0] conversion_result, conversion_result_next;
  logic [7:0]  clock_control, clock_control_next;
  logic [7:0]  amp_calibration, amp_calibration_next;
  logic [31:0] last_sample_time, last_sample_time_next;

  logic        advance;
  logic [7:0]  rdata_next;
  logic        taken_next;
  logic [7:0]  pc_access;
  logic [31:0] elapsed;

  // Advance the held item when the result register is free or draining.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      req_q    <= req_type;
      addr_q   <= reg_address;
      wdata_q  <= write_data;
      now_q    <= time_now;
      sample_q <= load_counts;
    end
  end

  always_comb begin
    power_control_next     = power_control;
    control_one_next       = control_one;
    control_two_next       = control_two;
    conversion_result_next = conversion_result;
    clock_control_next     = clock_control;
    amp_calibration_next   = amp_calibration;
    last_sample_time_next  = last_sample_time;
    rdata_next             = 8'h00;
    taken_next             = 1'b0;
    pc_access              = power_control;
    elapsed                = now_q - last_sample_time;

    unique case (req_q)
      REQ_READ: begin
        unique case (addr_q)
          ADDR_POWER:    rdata_next = power_control;
          ADDR_CTRL1:    rdata_next = control_one;
          ADDR_CTRL2:    rdata_next = control_two;
          ADDR_ADC_HI:   rdata_next = conversion_result[23:16];
          ADDR_ADC_MID:  rdata_next = conversion_result[15:8];
          ADDR_ADC_LO:   rdata_next = conversion_result[7:0];
          ADDR_CLOCK:    rdata_next = clock_control;
          ADDR_AMP_CAL:  rdata_next = amp_calibration;
          ADDR_REVISION: rdata_next = REVISION_ID;
          default:       rdata_next = 8'h00;
        endcase
        if (is_powered(pc_access)) begin
          pc_access[PWR_READY_BIT] = 1'b1;
        end
        power_control_next = pc_access;
      end
      REQ_WRITE: begin
        unique case (addr_q)
          ADDR_POWER:   pc_access            = wdata_q;
          ADDR_CTRL1:   control_one_next     = wdata_q;
          ADDR_CTRL2:   control_two_next     = wdata_q;
          ADDR_CLOCK:   clock_control_next   = wdata_q;
          ADDR_AMP_CAL: amp_calibration_next = wdata_q;
          default:      ;
        endcase
        if (is_powered(pc_access)) begin
          pc_access[PWR_READY_BIT] = 1'b1;
        end
        power_control_next = pc_access;
      end
      REQ_TICK: begin
        // Convert once the selected interval has elapsed.
        if (is_powered(power_control) &&
            elapsed >= 32'(rate_interval(control_two[6:4]))) begin
          last_sample_time_next              = now_q;
          conversion_result_next             = sample_q;
          power_control_next[PWR_CONV_BIT]   = 1'b1;
          power_control_next[PWR_READY_BIT]  = 1'b1;
          taken_next                         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register and register file update together.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      power_control     <= 8'h00;
      control_one       <= 8'h00;
      control_two       <= 8'h00;
      conversion_result <= 24'h000000;
      clock_control     <= 8'h00;
      amp_calibration   <= 8'h00;
      last_sample_time  <= 32'h0;
    end else begin
      if (advance) begin
        out_valid         <= 1'b1;
        power_control     <= power_control_next;
        control_one       <= control_one_next;
        control_two       <= control_two_next;
        conversion_result <= conversion_result_next;
        clock_control     <= clock_control_next;
        amp_calibration   <= amp_calibration_next;
        last_sample_time  <= last_sample_time_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      read_data    <= rdata_next;
      sample_taken <= taken_next;
    end
  end

endmodule

`default_nettype wire

[rtl/load_adc_register_device_top_checker.sv]
// ---------------------------------------------------------------------------
// Load ADC register device checker
// Port-level properties of the top level, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none

`include "load_adc_register_device_top_defines.svh"

module load_adc_register_device_top_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] read_data,
  input wire logic       sample_taken
);

  // A stalled result holds.
  `LADC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(sample_taken), "result changed while stalled")

  // Intake never stalls while the output side is free.
  `LADC_ASSERT_IMP(a_in_free, !out_valid || out_ready, in_ready, "intake stalled with output free")

  // A tick result carries no read byte.
  `LADC_ASSERT_IMP(a_tick_zero, out_valid && sample_taken, read_data == 8'h00, "sample result with read data")

endmodule

bind load_adc_register_device_top load_adc_register_device_top_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_data    (read_data),
  .sample_taken (sample_taken)
);

`default_nettype wire
